FILE: design/triangle_cull_and_near_clip_core_assert.svh
// Assertion macros shared by the triangle cull and clip RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_CULL_AND_NEAR_CLIP_CORE_ASSERT_SVH
`define TRIANGLE_CULL_AND_NEAR_CLIP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TCNC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tcnc check failed");
`define TCNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcnc check failed");
`else
`define TCNC_ASSERT(lbl, clk, rst_n, prop)
`define TCNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/tcnc_pkg.sv
// Shared types and constants for the triangle cull and near clip core.
// No dependencies.
package tcnc_pkg;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FAR  = 1'b1;
	localparam int COLOR_BITS = 64;
	localparam int NUM_COORDS = 8;

	// classification handed from front to back with each triangle
	typedef struct packed {
		logic [2:0] in_mask;
	} tcnc_job_t;
endpackage

FILE: design/tcnc_fifo.sv
// Small register queue used between front and back and at the result side.
// No dependencies.
module tcnc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

FILE: design/tcnc_front.sv
// Front end: gathers three vertices, culls, classifies against the near plane.
// Uses tcnc_pkg; feeds the job queue.
module tcnc_front #(
	parameter int W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [8*W+63:0]          vin,
	output logic                     full,
	input  logic signed [W-1:0]      near_z,
	input  logic signed [W-1:0]      far_z,
	output logic                     job_push,
	output logic [3*(8*W+64)+2:0]    job_data,
	input  logic                     job_full
);
	import tcnc_pkg::*;
	localparam int VW = 8*W + 64;

	logic [VW-1:0] vtx_q [3];
	logic [1:0] slot_q;
	logic pend_q;
	logic signed [W-1:0] z [3], cx [3], cy [3];
	logic signed [W-1:0] zmax, zmin, xmn, xmx, ymn, ymx;
	logic signed [W:0] nzmax;
	logic survive;
	tcnc_job_t ctl;

	assign full = pend_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cx[i] = vtx_q[i][0 +: W];
			cy[i] = vtx_q[i][W +: W];
			z[i]  = vtx_q[i][2*W +: W];
			ctl.in_mask[i] = (z[i] >= near_z);
		end
		zmax = z[0]; zmin = z[0];
		xmn = cx[0]; xmx = cx[0]; ymn = cy[0]; ymx = cy[0];
		for (int i = 1; i < 3; i++) begin
			if (z[i] > zmax) zmax = z[i];
			if (z[i] < zmin) zmin = z[i];
			if (cx[i] < xmn) xmn = cx[i];
			if (cx[i] > xmx) xmx = cx[i];
			if (cy[i] < ymn) ymn = cy[i];
			if (cy[i] > ymx) ymx = cy[i];
		end
		nzmax = -(W+1)'(zmax);
		survive = !(zmax < near_z || zmin > far_z)
			&& !((W+1)'(xmn) > (W+1)'(zmax) || (W+1)'(xmx) < nzmax)
			&& !((W+1)'(ymn) > (W+1)'(zmax) || (W+1)'(ymx) < nzmax);
	end

	assign job_push = pend_q && survive && !job_full;
	assign job_data = {ctl, vtx_q[2], vtx_q[1], vtx_q[0]};

	always_ff @(posedge clk) begin
		if (push && !full) vtx_q[slot_q] <= vin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (push && !full) begin
				if (slot_q == 2'd2) begin
					slot_q <= '0;
					pend_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			// culled triangles are dropped here
			if (pend_q && (!survive || !job_full)) pend_q <= 1'b0;
		end
	end
endmodule

FILE: design/tcnc_back.sv
// Back end: weight divider, shared lerp multiplier and output sequencer.
// Uses tcnc_pkg and the assertion header; feeds the result queue.
`include "triangle_cull_and_near_clip_core_assert.svh"
module tcnc_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	input  logic [3*(8*W+64)+2:0]    job_data,
	output logic                     job_pop,
	input  logic signed [W-1:0]      near_z,
	output logic                     out_push,
	output logic [8*W+64:0]          out_data,
	input  logic                     out_full
);
	import tcnc_pkg::*;
	localparam int VW = 8*W + 64;
	localparam int NATTR = NUM_COORDS + 4;
	localparam int CW = $clog2(F + NATTR + 1);
	localparam logic [2:0] SRC_IN0 = 3'd0, SRC_IN1 = 3'd1, SRC_V2 = 3'd2,
		SRC_NA = 3'd3, SRC_NB = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_PREP = 5'b00010, ST_DIV = 5'b00100,
		ST_LERP = 5'b01000, ST_EMIT = 5'b10000
	} st_t;

	st_t st_q;
	logic [VW-1:0] jv_q [3];
	logic [1:0] in0_q, in1_q, out0_q, out1_q, ni_q;
	logic k_q;
	logic [CW-1:0] cnt_q;
	logic [2:0] ecnt_q;
	logic [W+1:0] rem_q, d_q, rem2;
	logic [F-1:0] t_q;
	logic [W-1:0] nv_q [2][NATTR];
	logic [W+F:0] prod_s1;
	logic neg_s1, vld_s1;
	logic [W-1:0] a_s1;
	logic [3:0] idx_s1;

	tcnc_job_t ctl;
	logic [1:0] ni, in0, in1, out0, out1, ia, ib;
	logic [VW-1:0] va, vb, ev;
	logic signed [W:0] la, lb;
	logic signed [W+1:0] diff;
	logic [W:0] mag, pshift;
	logic [W-1:0] lres;
	logic [3:0] li;
	logic [2:0] src, total;

	function automatic logic signed [W-1:0] crd(logic [VW-1:0] v, int a);
		return v[a*W +: W];
	endfunction

	always_comb begin
		ctl = job_data[3*VW +: 3];
		ni = 2'($countones(ctl.in_mask));
		in0 = 2'd0; in1 = 2'd0; out0 = 2'd0; out1 = 2'd0;
		for (int i = 2; i >= 0; i--) begin
			if (ctl.in_mask[i]) begin
				in1 = in0; in0 = 2'(i);
			end else begin
				out1 = out0; out0 = 2'(i);
			end
		end
	end

	assign job_pop = (st_q == ST_IDLE) && job_valid;

	// endpoints of the edge being cut
	assign ia = (k_q && ni_q == 2'd2) ? in1_q : in0_q;
	assign ib = (k_q && ni_q == 2'd1) ? out1_q : out0_q;
	assign va = jv_q[ia];
	assign vb = jv_q[ib];
	assign rem2 = {rem_q[W:0], 1'b0};

	always_comb begin
		li = cnt_q[3:0];
		if (li < 4'(NUM_COORDS)) begin
			la = (W+1)'(crd(va, int'(li)));
			lb = (W+1)'(crd(vb, int'(li)));
		end else begin
			la = (W+1)'({1'b0, va[8*W + 16*(int'(li) - NUM_COORDS) +: 16]});
			lb = (W+1)'({1'b0, vb[8*W + 16*(int'(li) - NUM_COORDS) +: 16]});
		end
		diff = (W+2)'(lb) - (W+2)'(la);
		mag = diff[W+1] ? (W+1)'(-diff) : (W+1)'(diff);
		pshift = (W+1)'(prod_s1 >> F);
		lres = neg_s1 ? a_s1 - pshift[W-1:0] : a_s1 + pshift[W-1:0];
	end

	always_comb begin
		total = (ni_q == 2'd2) ? 3'd6 : 3'd3;
		case (ni_q)
			2'd1: src = (ecnt_q == 3'd0) ? SRC_IN0 : (ecnt_q == 3'd1) ? SRC_NA : SRC_NB;
			2'd2: begin
				case (ecnt_q)
					3'd0: src = SRC_IN0;
					3'd1: src = SRC_IN1;
					3'd2: src = SRC_NA;
					3'd3: src = SRC_IN1;
					3'd4: src = SRC_NB;
					default: src = SRC_NA;
				endcase
			end
			default: src = ecnt_q;
		endcase
		case (src)
			SRC_IN0: ev = jv_q[in0_q];
			SRC_IN1: ev = jv_q[in1_q];
			SRC_V2:  ev = jv_q[2];
			default: begin
				for (int i = 0; i < NUM_COORDS; i++) ev[i*W +: W] = nv_q[src == SRC_NB][i];
				ev[2*W +: W] = near_z;
				for (int c = 0; c < 4; c++)
					ev[8*W + 16*c +: 16] = nv_q[src == SRC_NB][NUM_COORDS + c][15:0];
			end
		endcase
	end

	assign out_push = (st_q == ST_EMIT) && !out_full;
	assign out_data = {(ecnt_q == total - 3'd1), ev};

	always_ff @(posedge clk) begin
		if (job_pop) begin
			jv_q[0] <= job_data[0 +: VW];
			jv_q[1] <= job_data[VW +: VW];
			jv_q[2] <= job_data[2*VW +: VW];
			ni_q <= ni; in0_q <= in0; in1_q <= in1; out0_q <= out0; out1_q <= out1;
		end
		if (st_q == ST_PREP) begin
			rem_q <= (W+2)'(crd(va, 2)) - (W+2)'(near_z);
			d_q <= (W+2)'(crd(va, 2)) - (W+2)'(crd(vb, 2));
			t_q <= '0;
		end else if (st_q == ST_DIV) begin
			if (rem2 >= d_q) begin
				rem_q <= rem2 - d_q;
				t_q <= {t_q[F-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				t_q <= {t_q[F-2:0], 1'b0};
			end
		end
		prod_s1 <= (W+F+1)'(mag) * (W+F+1)'(t_q);
		neg_s1 <= diff[W+1];
		a_s1 <= la[W-1:0];
		idx_s1 <= li;
		if (vld_s1) nv_q[k_q][idx_s1] <= lres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= 1'b0;
			cnt_q <= '0;
			ecnt_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (st_q == ST_LERP) && (cnt_q < CW'(NATTR));
			case (st_q)
				ST_IDLE: if (job_valid) begin
					k_q <= 1'b0;
					ecnt_q <= '0;
					st_q <= (ni == 2'd3) ? ST_EMIT : ST_PREP;
				end
				ST_PREP: begin
					cnt_q <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CW'(F - 1)) begin
						cnt_q <= '0;
						st_q <= ST_LERP;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_LERP: begin
					if (cnt_q == CW'(NATTR)) begin
						cnt_q <= '0;
						k_q <= 1'b1;
						st_q <= k_q ? ST_EMIT : ST_PREP;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_EMIT: if (!out_full) begin
					if (ecnt_q == total - 3'd1) begin
						ecnt_q <= '0;
						st_q <= ST_IDLE;
					end else ecnt_q <= ecnt_q + 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`TCNC_ASSERT_IMP(a_div_rem, clk, arst_n, st_q == ST_DIV, rem_q < d_q)
	`TCNC_ASSERT_IMP(a_emit_cnt, clk, arst_n, st_q == ST_EMIT, ecnt_q < total)
	`TCNC_ASSERT_IMP(a_pop_idle, clk, arst_n, job_pop, $past(st_q) != ST_IDLE || st_q == ST_IDLE)
	`TCNC_ASSERT(a_clip_one_out, clk, arst_n, !(job_pop && ni == 2'd0))
endmodule

FILE: design/triangle_cull_and_near_clip_core.sv
// Top level: configuration registers, front end, job queue, back end, result queue.
// Uses tcnc_pkg, tcnc_fifo, tcnc_front, tcnc_back.
//
// channel  | handshake         | word
// input    | push / full       | one vertex (position, normal, color, texture)
// result   | pop / empty       | one output vertex plus run_last
// config   | cfg_we            | cfg_idx selects near or far plane, cfg_wdata
//
// A vertex is taken whenever full is low; after the third of a triangle, full stays
// high while it is culled and classified and, if it survives, until the job queue
// has room. Fully inside triangles go straight to emitting their three vertices in
// the back end; a clipped one runs, for each of its two new vertices, the bit-serial
// weight divider and the single shared lerp multiplier over 12 attributes.
// Reset clears all control state; vertex data is unknown until written.
// A two-entry job queue and a two-entry result queue let either side stall alone.
module triangle_cull_and_near_clip_core #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [WORD_BITS-1:0] pos_x,
	input  logic signed [WORD_BITS-1:0] pos_y,
	input  logic signed [WORD_BITS-1:0] pos_z,
	input  logic signed [WORD_BITS-1:0] normal_x,
	input  logic signed [WORD_BITS-1:0] normal_y,
	input  logic signed [WORD_BITS-1:0] normal_z,
	input  logic [tcnc_pkg::COLOR_BITS-1:0] color_rgba,
	input  logic signed [WORD_BITS-1:0] tex_u,
	input  logic signed [WORD_BITS-1:0] tex_v,
	output logic empty,
	input  logic pop,
	output logic signed [WORD_BITS-1:0] out_pos_x,
	output logic signed [WORD_BITS-1:0] out_pos_y,
	output logic signed [WORD_BITS-1:0] out_pos_z,
	output logic signed [WORD_BITS-1:0] out_normal_x,
	output logic signed [WORD_BITS-1:0] out_normal_y,
	output logic signed [WORD_BITS-1:0] out_normal_z,
	output logic [tcnc_pkg::COLOR_BITS-1:0] out_color_rgba,
	output logic signed [WORD_BITS-1:0] out_tex_u,
	output logic signed [WORD_BITS-1:0] out_tex_v,
	output logic run_last,
	input  logic cfg_we,
	input  logic [tcnc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [WORD_BITS-1:0] cfg_wdata
);
	import tcnc_pkg::*;
	localparam int W = WORD_BITS;
	localparam int VW = 8*W + 64;
	localparam int JW = 3*VW + 3;

	logic signed [W-1:0] near_q, far_q;
	logic [VW-1:0] vin;
	logic jq_push, jq_full, jq_pop, jq_empty;
	logic [JW-1:0] jq_wdata, jq_rdata;
	logic rq_push, rq_full;
	logic [VW:0] rq_wdata, rq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= W'(6554);
			far_q <= W'(6553600);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NEAR: near_q <= cfg_wdata;
				CFG_FAR:  far_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign vin = {color_rgba, tex_v, tex_u, normal_z, normal_y, normal_x, pos_z, pos_y, pos_x};

	tcnc_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .vin(vin), .full(full),
		.near_z(near_q), .far_z(far_q),
		.job_push(jq_push), .job_data(jq_wdata), .job_full(jq_full)
	);

	tcnc_fifo #(.WIDTH(JW), .DEPTH(2)) u_jobq (
		.clk(clk), .arst_n(arst_n), .push(jq_push), .wdata(jq_wdata), .full(jq_full),
		.pop(jq_pop), .rdata(jq_rdata), .empty(jq_empty)
	);

	tcnc_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(!jq_empty), .job_data(jq_rdata),
		.job_pop(jq_pop), .near_z(near_q),
		.out_push(rq_push), .out_data(rq_wdata), .out_full(rq_full)
	);

	tcnc_fifo #(.WIDTH(VW + 1), .DEPTH(2)) u_resq (
		.clk(clk), .arst_n(arst_n), .push(rq_push), .wdata(rq_wdata), .full(rq_full),
		.pop(pop), .rdata(rq_rdata), .empty(empty)
	);

	assign out_pos_x      = rq_rdata[0 +: W];
	assign out_pos_y      = rq_rdata[W +: W];
	assign out_pos_z      = rq_rdata[2*W +: W];
	assign out_normal_x   = rq_rdata[3*W +: W];
	assign out_normal_y   = rq_rdata[4*W +: W];
	assign out_normal_z   = rq_rdata[5*W +: W];
	assign out_tex_u      = rq_rdata[6*W +: W];
	assign out_tex_v      = rq_rdata[7*W +: W];
	assign out_color_rgba = rq_rdata[8*W +: COLOR_BITS];
	assign run_last       = rq_rdata[VW];
endmodule
